>>> rtl/core/bss_pkg.sv
// shared types and constants for the byte signature scanner
`default_nettype none

package bss_pkg;

  localparam int DEF_MAX_PATTERN = 64;
  localparam int DEF_WORD_BYTES  = 4;

  localparam int BYTE_W  = 8;
  localparam int OFF_W   = 32;
  localparam int RANGE_W = 32;
  localparam int IDX_W   = 1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SCAN = 1'b1;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [IDX_W-1:0] REG_RANGE_START = 1'b0;
  localparam logic [IDX_W-1:0] REG_RANGE_END   = 1'b1;

  typedef struct packed {
    logic shift;
    logic scan;
    logic clr;
  } bss_cell_ctl_t;

  typedef struct packed {
    logic             kind;
    logic [OFF_W-1:0] match_offset;
    logic             found_any;
  } bss_res_t;

endpackage

`default_nettype wire

>>> rtl/core/bss_if.sv
// valid/ready channel interfaces for image and result words
`default_nettype none

interface bss_in_if import bss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output action, output data_byte, output last, input ready);
  modport sink (input valid, input action, input data_byte, input last, output ready);
endinterface

interface bss_out_if import bss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [OFF_W-1:0] match_offset;
  logic             found_any;

  modport source (output valid, output kind, output match_offset, output found_any, input ready);
  modport sink (input valid, input kind, input match_offset, input found_any, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bss_cell.sv
// one comparator cell: signature byte, wildcard bit and partial match flag
`default_nettype none

module bss_cell import bss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bss_cell_ctl_t     ctl,
  input  wire logic              head,
  input  wire logic [BYTE_W-1:0] pat_in,
  input  wire logic              wild_in,
  input  wire logic              hit_in,
  input  wire logic [BYTE_W-1:0] img,
  output logic      [BYTE_W-1:0] pat_o,
  output logic                   wild_o,
  output logic                   hit_o,
  output logic                   hit_nxt_o
);

  logic [BYTE_W-1:0] pat_r;
  logic              wild_r;
  logic              hit_r;
  logic              hit_nxt;

  assign hit_nxt = (head | hit_in) & (wild_r | (pat_r == img));

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      pat_r  <= pat_in;
      wild_r <= wild_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.clr) begin
      hit_r <= 1'b0;
    end else if (ctl.scan) begin
      hit_r <= hit_nxt;
    end
  end

  assign pat_o     = pat_r;
  assign wild_o    = wild_r;
  assign hit_o     = hit_r;
  assign hit_nxt_o = hit_nxt;

endmodule

`default_nettype wire

>>> rtl/core/bss_walk.sv
// wildcard walk: range check of the word at the row head and skip count
`default_nettype none

module bss_walk import bss_pkg::*; #(
  parameter int WORD_BYTES = DEF_WORD_BYTES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       step,
  input  wire logic                       take,
  input  wire logic [8*WORD_BYTES-1:0]    word,
  input  wire logic [RANGE_W-1:0]         range_lo,
  input  wire logic [RANGE_W-1:0]         range_hi,
  output logic                            wild
);

  localparam int WORD_W = 8 * WORD_BYTES;
  localparam int SKIP_W = $clog2(WORD_BYTES);

  logic [SKIP_W-1:0] skip_r;
  logic [SKIP_W-1:0] skip_nxt;
  logic              in_range;

  assign in_range = (word >= WORD_W'(range_lo)) && (word < WORD_W'(range_hi));

  always_comb begin
    wild     = 1'b0;
    skip_nxt = skip_r;
    if (skip_r != '0) begin
      wild     = 1'b1;
      skip_nxt = skip_r - SKIP_W'(1);
    end else if (take && in_range) begin
      wild     = 1'b1;
      skip_nxt = SKIP_W'(WORD_BYTES - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= '0;
    end else if (start) begin
      skip_r <= '0;
    end else if (step) begin
      skip_r <= skip_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/byte_signature_scanner.sv
// top level: signature load, mask build over the cell row, scan and result queue
// one image byte per cycle outside mask build and while the result queue has room;
// an image word may yield a match and a summary; a two-entry register queue holds both
// each signature byte is followed by a mask build that rotates the row once around
// synchronous active-low reset clears length, position, match flags, queue and ranges
`default_nettype none

module byte_signature_scanner import bss_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int WORD_BYTES  = DEF_WORD_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  bss_in_if.sink                  in_bus,
  bss_out_if.source               out_bus,
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_idx,
  input  wire logic [RANGE_W-1:0] cfg_wdata
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int EXT_W = LEN_W + 1;
  localparam int R_W   = $clog2(MAX_PATTERN);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_BUILD = 2'b10
  } state_t;

  state_t             state_r;
  logic [LEN_W-1:0]   len_r;
  logic               closed_r;
  logic [R_W-1:0]     r_r;
  logic [OFF_W-1:0]   pos_r;
  logic               seen_r;
  logic [RANGE_W-1:0] rs_r, re_r, rs_snap_r, re_snap_r;
  bss_res_t           q_r [2];
  logic [1:0]         cnt_r;

  logic               acc, load_acc, scan_acc, building, load_shift;
  logic [LEN_W-1:0]   len_eff;
  bss_cell_ctl_t      ctl;
  logic [BYTE_W-1:0]  pat  [MAX_PATTERN];
  logic               wild [MAX_PATTERN];
  logic               hit  [MAX_PATTERN];
  logic               hit_now [MAX_PATTERN];
  logic [8*WORD_BYTES-1:0] word;
  logic               walk_wild, is_pat, fits;
  logic [EXT_W-1:0]   r_x;
  logic               match, push_m, push_s, pop;
  bss_res_t           match_res, sum_res;
  bss_res_t           pk0, pk1, b0;
  logic [1:0]         cnt_pop, cnt_nxt;

  assign building = (state_r == ST_BUILD);
  assign pop      = out_bus.valid && out_bus.ready;
  assign in_bus.ready = (state_r == ST_RUN) && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop));
  assign acc      = in_bus.valid && in_bus.ready;
  assign load_acc = acc && (in_bus.action == ACT_LOAD);
  assign scan_acc = acc && (in_bus.action == ACT_SCAN);

  assign len_eff    = closed_r ? '0 : len_r;
  assign load_shift = load_acc && (len_eff < LEN_W'(MAX_PATTERN));

  assign ctl.shift = load_shift | building;
  assign ctl.scan  = scan_acc;
  assign ctl.clr   = load_acc | (scan_acc & in_bus.last);

  // cell row
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [BYTE_W-1:0] p_in;
    logic              w_in;
    logic              h_in;
    logic              head;

    if (k == MAX_PATTERN - 1) begin : g_end
      assign p_in = building ? pat[0] : in_bus.data_byte;
      assign w_in = building ? walk_wild : 1'b0;
    end else begin : g_mid
      assign p_in = pat[k+1];
      assign w_in = wild[k+1];
    end

    if (k == 0) begin : g_first
      assign h_in = 1'b0;
    end else begin : g_rest
      assign h_in = hit[k-1];
    end

    assign head = (len_r == LEN_W'(MAX_PATTERN - k));

    bss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .head      (head),
      .pat_in    (p_in),
      .wild_in   (w_in),
      .hit_in    (h_in),
      .img       (in_bus.data_byte),
      .pat_o     (pat[k]),
      .wild_o    (wild[k]),
      .hit_o     (hit[k]),
      .hit_nxt_o (hit_now[k])
    );
  end

  // word at the row head, little-endian
  for (genvar j = 0; j < WORD_BYTES; j++) begin : g_word
    assign word[8*j +: 8] = pat[j];
  end

  assign r_x    = EXT_W'(r_r);
  assign is_pat = (r_x + EXT_W'(len_r)) >= EXT_W'(MAX_PATTERN);
  assign fits   = (r_x + EXT_W'(WORD_BYTES)) <= EXT_W'(MAX_PATTERN);

  bss_walk #(.WORD_BYTES(WORD_BYTES)) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (load_acc),
    .step     (building),
    .take     (is_pat && fits),
    .word     (word),
    .range_lo (rs_snap_r),
    .range_hi (re_snap_r),
    .wild     (walk_wild)
  );

  // results
  assign match  = (len_r == '0) || hit_now[MAX_PATTERN-1];
  assign push_m = scan_acc && match;
  assign push_s = scan_acc && in_bus.last;

  assign match_res.kind         = KIND_MATCH;
  assign match_res.match_offset = (len_r == '0) ? pos_r
                                  : (pos_r + OFF_W'(1) - OFF_W'(len_r));
  assign match_res.found_any    = 1'b0;

  assign sum_res.kind         = KIND_SUMMARY;
  assign sum_res.match_offset = '0;
  assign sum_res.found_any    = seen_r | push_m;

  assign pk0     = push_m ? match_res : sum_res;
  assign pk1     = sum_res;
  assign cnt_pop = cnt_r - {1'b0, pop};
  assign b0      = pop ? q_r[1] : q_r[0];
  assign cnt_nxt = cnt_pop + {1'b0, push_m} + {1'b0, push_s};

  always_ff @(posedge clk) begin
    if (cnt_pop == 2'd0) begin
      q_r[0] <= pk0;
      q_r[1] <= pk1;
    end else if (cnt_pop == 2'd1) begin
      q_r[0] <= b0;
      q_r[1] <= pk0;
    end else begin
      q_r[0] <= b0;
      q_r[1] <= q_r[1];
    end
  end

  assign out_bus.valid        = (cnt_r != 2'd0);
  assign out_bus.kind         = q_r[0].kind;
  assign out_bus.match_offset = q_r[0].match_offset;
  assign out_bus.found_any    = q_r[0].found_any;

  // range snapshot taken with each signature word
  always_ff @(posedge clk) begin
    if (load_acc) begin
      rs_snap_r <= rs_r;
      re_snap_r <= re_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RUN;
      len_r    <= '0;
      closed_r <= 1'b0;
      r_r      <= '0;
      pos_r    <= '0;
      seen_r   <= 1'b0;
      rs_r     <= '0;
      re_r     <= '0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;

      if (cfg_we) begin
        case (cfg_idx)
          REG_RANGE_START: rs_r <= cfg_wdata;
          REG_RANGE_END:   re_r <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        ST_RUN: begin
          if (load_acc) begin
            state_r  <= ST_BUILD;
            r_r      <= '0;
            pos_r    <= '0;
            seen_r   <= 1'b0;
            closed_r <= in_bus.last;
            len_r    <= load_shift ? (len_eff + LEN_W'(1)) : len_eff;
          end else if (scan_acc) begin
            closed_r <= 1'b1;
            if (in_bus.last) begin
              pos_r  <= '0;
              seen_r <= 1'b0;
            end else begin
              pos_r  <= pos_r + OFF_W'(1);
              seen_r <= seen_r | match;
            end
          end
        end
        ST_BUILD: begin
          r_r <= r_r + R_W'(1);
          if (r_r == R_W'(MAX_PATTERN - 1)) begin
            state_r <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue overfilled");

  a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (state_r == ST_RUN))
    else $error("word taken outside run state");

  a_load_build: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> (state_r == ST_BUILD) && (r_r == '0))
    else $error("mask build not started after signature word");

  a_build_end: assert property (@(posedge clk) disable iff (!rst_n)
    (building && (r_r == R_W'(MAX_PATTERN - 1))) |=> (state_r == ST_RUN))
    else $error("mask build did not end");

  a_summary_clear: assert property (@(posedge clk) disable iff (!rst_n)
    push_s |=> (pos_r == '0) && !seen_r)
    else $error("scan state not cleared after summary");

endmodule

`default_nettype wire

>>> tb/byte_signature_scanner_test.sv
`timescale 1ns / 100ps
// testbench for byte_signature_scanner: directed and random signature scans checked by a predictor

module byte_signature_scanner_test;
  import bss_pkg::*;

  localparam int MAX_PATTERN   = DEF_MAX_PATTERN;
  localparam int WORD_BYTES    = DEF_WORD_BYTES;
  localparam int SETTLE_CYCLES = 2 * MAX_PATTERN + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int TARGET_WORDS  = 1700;
  localparam int QUIET_FROM    = 1450;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_idx;
  logic [RANGE_W-1:0] cfg_wdata;

  bss_in_if  in_bus ();
  bss_out_if out_bus ();

  byte_signature_scanner #(
    .MAX_PATTERN(MAX_PATTERN),
    .WORD_BYTES (WORD_BYTES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // predicted state of the scanner
  logic [RANGE_W-1:0] wild_lo;
  logic [RANGE_W-1:0] wild_hi;
  logic [BYTE_W-1:0]  sig_bytes [MAX_PATTERN];
  bit                 sig_wild  [MAX_PATTERN];
  int unsigned        sig_len;
  bit                 sig_done;
  logic [BYTE_W-1:0]  img_win   [MAX_PATTERN];
  int unsigned        win_fill;
  logic [OFF_W-1:0]   img_pos;
  bit                 hit_seen;
  bss_res_t           expected_hits [$];

  bit          gaps_on;
  bit          stalls_on;
  bit          hold_results;
  int unsigned words_sent;
  int unsigned fail_count;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void clear_image_state();
    for (int k = 0; k < MAX_PATTERN; k++) img_win[k] = '0;
    win_fill = 0;
    img_pos  = '0;
    hit_seen = 1'b0;
  endfunction

  function automatic void rebuild_wildcards();
    int unsigned i;
    logic [63:0] w;
    bit          wild;
    for (int k = 0; k < MAX_PATTERN; k++) sig_wild[k] = 1'b0;
    i = 0;
    while (i < sig_len) begin
      wild = 1'b0;
      if (sig_len - i >= WORD_BYTES) begin
        w = '0;
        for (int k = 0; k < WORD_BYTES; k++) w[8*k +: 8] = sig_bytes[i+k];
        wild = (w >= {32'd0, wild_lo}) && (w < {32'd0, wild_hi});
      end
      if (wild) begin
        for (int k = 0; k < WORD_BYTES; k++) sig_wild[i+k] = 1'b1;
        i += WORD_BYTES;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic void predict_word(logic act, logic [BYTE_W-1:0] b, logic lst);
    bit          hit;
    int unsigned base;
    bss_res_t    r;
    if (act == ACT_LOAD) begin
      if (sig_done) begin
        sig_len  = 0;
        sig_done = 1'b0;
        clear_image_state();
      end
      if (sig_len < MAX_PATTERN) begin
        sig_bytes[sig_len] = b;
        sig_len++;
      end
      rebuild_wildcards();
      if (lst) sig_done = 1'b1;
    end else begin
      sig_done = 1'b1;
      for (int k = 0; k < MAX_PATTERN - 1; k++) img_win[k] = img_win[k+1];
      img_win[MAX_PATTERN-1] = b;
      if (win_fill < MAX_PATTERN) win_fill++;
      hit  = (win_fill >= sig_len);
      base = MAX_PATTERN - sig_len;
      for (int k = 0; k < sig_len; k++)
        if (!sig_wild[k] && img_win[base+k] != sig_bytes[k]) hit = 1'b0;
      if (hit) begin
        r.kind         = KIND_MATCH;
        r.match_offset = (sig_len == 0) ? img_pos : img_pos + 32'd1 - sig_len;
        r.found_any    = 1'b0;
        expected_hits = {expected_hits, r};
        hit_seen = 1'b1;
      end
      img_pos++;
      if (lst) begin
        r.kind         = KIND_SUMMARY;
        r.match_offset = '0;
        r.found_any    = hit_seen;
        expected_hits = {expected_hits, r};
        clear_image_state();
      end
    end
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte(bit narrow);
    return narrow ? BYTE_W'($urandom_range(0, 3)) : BYTE_W'($urandom);
  endfunction

  task automatic send_word(logic act, logic [BYTE_W-1:0] b, logic lst);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.action    <= act;
    in_bus.data_byte <= b;
    in_bus.last      <= lst;
    do @(posedge clk); while (!in_bus.ready);
    predict_word(act, b, lst);
    words_sent++;
  endtask

  task automatic drain_and_settle();
    in_bus.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_range(logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_RANGE_START;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx   <= REG_RANGE_END;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we  <= 1'b0;
    wild_lo = lo;
    wild_hi = hi;
  endtask

  task automatic send_bytes(logic act, logic [BYTE_W-1:0] s [$], bit close);
    foreach (s[k]) send_word(act, s[k], close && k == s.size() - 1);
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    bss_res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual kind=%0b offset=%0d found=%0b",
                 $time, out_bus.kind, out_bus.match_offset, out_bus.found_any);
        fail_count++;
      end else begin
        want = expected_hits.pop_front();
        if (out_bus.kind !== want.kind) begin
          $display("%0t: kind mismatch: expected %0b, actual %0b",
                   $time, want.kind, out_bus.kind);
          fail_count++;
        end
        if (out_bus.match_offset !== want.match_offset) begin
          $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                   $time, want.match_offset, out_bus.match_offset);
          fail_count++;
        end
        if (out_bus.found_any !== want.found_any) begin
          $display("%0t: found_any mismatch: expected %0b, actual %0b",
                   $time, want.found_any, out_bus.found_any);
          fail_count++;
        end
      end
    end
  end

  // result ready with random stalls and one long hold-off on request
  initial begin : result_ready
    int n;
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_bus.ready <= 1'b0;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
        out_bus.ready <= 1'b1;
        hold_results = 1'b0;
      end else if (stalls_on && $urandom_range(0, 6) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic test_empty_signature();
    send_bytes(ACT_SCAN, '{8'h00, 8'hFF, 8'h5A}, 1'b1);
  endtask

  task automatic test_wildcard_word();
    set_range(32'h0040_1000, 32'h0040_2000);
    send_bytes(ACT_LOAD, '{8'h8B, 8'h00, 8'h14, 8'h40, 8'h00, 8'hC3}, 1'b1);
    send_bytes(ACT_SCAN, '{8'h8B, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hC3,
                           8'h8B, 8'h00, 8'h14, 8'h40, 8'h00, 8'hC4}, 1'b1);
  endtask

  // new ranges must not touch the mask until the next signature word
  task automatic test_stale_mask();
    set_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_bytes(ACT_SCAN, '{8'h8B, 8'h11, 8'h22, 8'h33, 8'h44, 8'hC3}, 1'b1);
  endtask

  task automatic test_scan_during_load();
    send_bytes(ACT_LOAD, '{8'h00, 8'hFF}, 1'b0);
    send_bytes(ACT_SCAN, '{8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1);
  endtask

  task automatic test_result_backpressure();
    drain_and_settle();
    send_word(ACT_LOAD, 8'hA5, 1'b1);
    hold_results = 1'b1;
    repeat (29) send_word(ACT_SCAN, 8'hA5, 1'b0);
    send_word(ACT_SCAN, 8'hA5, 1'b1);
    drain_and_settle();
  endtask

  task automatic test_random_streams();
    logic [BYTE_W-1:0]  sig [$];
    logic [63:0]        v;
    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi;
    int unsigned        len;
    int unsigned        slen;
    int unsigned        cnt;
    int unsigned        plen;
    int unsigned        j;
    int unsigned        phase;
    bit                 narrow;
    bit                 noise;
    bit                 quiet;
    phase = 0;
    while (words_sent < TARGET_WORDS) begin
      quiet     = (words_sent >= QUIET_FROM);
      gaps_on   = !quiet && $urandom_range(0, 3) != 0;
      stalls_on = !quiet && $urandom_range(0, 3) != 0;
      narrow    = 1'($urandom_range(0, 1));
      if (phase == 0 || $urandom_range(0, 7) == 0) len = $urandom_range(60, 70);
      else len = $urandom_range(1, 12);
      sig = {};
      repeat (len) sig = {sig, pick_byte(narrow)};
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0: begin
            lo = '0;
            hi = '1;
          end
          1: begin
            lo = $urandom;
            hi = lo;
          end
          2: begin
            lo = '1;
            hi = '0;
          end
          3: begin
            lo = $urandom;
            hi = $urandom;
          end
          default: begin
            j = (len >= WORD_BYTES) ? $urandom_range(0, len - WORD_BYTES) : 0;
            v = '0;
            for (int k = 0; k < WORD_BYTES && j + k < len; k++) v[8*k +: 8] = sig[j+k];
            lo = v[31:0] - ((v[31:0] < 3) ? v[31:0] : RANGE_W'($urandom_range(0, 3)));
            hi = (v[31:0] > 32'hFFFF_FFFB) ? 32'hFFFF_FFFF
                                            : v[31:0] + 32'd1 + $urandom_range(0, 3);
          end
        endcase
        set_range(lo, hi);
      end
      send_bytes(ACT_LOAD, sig, $urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) == 0) set_range($urandom, $urandom);
      repeat ($urandom_range(1, 3)) begin
        noise = ($urandom_range(0, 4) == 0);
        slen  = $urandom_range(6, 40) + ((sig_len > 12) ? sig_len : 0);
        cnt   = 0;
        while (cnt < slen) begin
          if (noise) begin
            send_word(($urandom_range(0, 5) == 0) ? ACT_LOAD : ACT_SCAN,
                      BYTE_W'($urandom), $urandom_range(0, 7) == 0);
            cnt++;
          end else if ($urandom_range(0, 2) != 0) begin
            send_word(ACT_SCAN, pick_byte(narrow), 1'b0);
            cnt++;
          end else begin
            plen = sig_len;
            for (int k = 0; k < plen; k++)
              send_word(ACT_SCAN, sig_wild[k] ? BYTE_W'($urandom) : sig_bytes[k], 1'b0);
            cnt += (plen == 0) ? 1 : plen;
          end
        end
        if ($urandom_range(0, 7) != 0) send_word(ACT_SCAN, pick_byte(narrow), 1'b1);
      end
      phase++;
    end
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
  endtask

  initial begin : limit
    #40_000_000;
    $display("FAIL byte_signature_scanner");
    $finish;
  end

  initial begin : run
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_RANGE_START;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.action    <= ACT_LOAD;
    in_bus.data_byte <= '0;
    in_bus.last      <= 1'b0;
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    hold_results = 1'b0;
    words_sent   = 0;
    fail_count   = 0;
    wild_lo      = '0;
    wild_hi      = '0;
    sig_len      = 0;
    sig_done     = 1'b0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      sig_bytes[k] = '0;
      sig_wild[k]  = 1'b0;
    end
    clear_image_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_signature();
    test_wildcard_word();
    test_stale_mask();
    test_scan_during_load();
    test_result_backpressure();
    test_random_streams();

    drain_and_settle();
    if (fail_count == 0) begin
      $display("PASS byte_signature_scanner");
    end else begin
      $display("FAIL byte_signature_scanner");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bss_pkg.sv
rtl/core/bss_if.sv
rtl/core/bss_cell.sv
rtl/core/bss_walk.sv
rtl/core/byte_signature_scanner.sv
tb/byte_signature_scanner_test.sv
